// ----- design/lvfg_pkg.sv -----
// Shared types and constants of the LiPo voltage fuel gauge.
package lvfg_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;

    // Field widths
    localparam int VOLT_W = 16;
    localparam int TIME_W = 32;
    localparam int PCT_W  = 14;
    localparam int MAH_W  = 16;
    localparam int TL_W   = 32;
    localparam int CELL_W = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Per-cell voltage span: empty at 3700 mV, full at 4200 mV
    localparam int MV_EMPTY_PER_CELL = 3700;
    // 10000 hundredths over a 500 mV span per cell
    localparam int PCT_SCALE = 20;
    localparam int PCT_MAX   = 10000;
    localparam int CAP_DIV   = 10000;
    localparam int FRAC_BITS = 24;

    // Capacity scaling: x / 10000 = ((x >> 4) * CAP_RECIP) >> CAP_SHIFT for x < 2^30
    localparam int CAP_PRE_SHIFT = 4;
    localparam int CAPX_W        = 26;
    localparam int CAP_RECIP     = 109951163;
    localparam int CAP_SHIFT     = 36;
    localparam int CAP_PROD_W    = CAPX_W + 27;

    // Divider geometry: a pair term is below 2^56, a divisor fits 16 bits
    localparam int TERM_W = 56;
    localparam int DEN_W  = 16;

    localparam logic [CELL_W-1:0] CELLS_RST = 4'd3;
    localparam logic [MAH_W-1:0]  CAP_RST   = 16'd2200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_COUNT = 1'b0,
        CFG_TOTAL_CAP  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PCT,
        ST_PCT_WAIT,
        ST_CAP,
        ST_CAP_WAIT,
        ST_RD,
        ST_LAT,
        ST_PAIR,
        ST_PAIR_WAIT,
        ST_NEXT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_MUL,
        ST_SAT,
        ST_DONE
    } t_state;

endpackage

// ----- design/lvfg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lvfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lvfg_divu.sv -----
// Shared unsigned restoring divider, one quotient bit per cycle.
module lvfg_divu #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] w_shift;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- design/lipo_voltage_fuel_gauge.sv -----
// LiPo pack fuel gauge: state of charge, remaining capacity and time-left estimate.
// One sample is taken at a time; o_stall stays high until its result has been
// loaded into the output register. The percent scaling, each pair term of the
// history whose voltages differ, and the mean run through one shared radix-2
// divider with NUM_W = 56 + clog2(HISTORY_DEPTH) (60 by default); the capacity
// uses a reciprocal multiply and the final scaling is a shift-add multiply. A
// stalled output register holds a finished result back until it is free.
module lipo_voltage_fuel_gauge #(
    parameter int HISTORY_DEPTH = lvfg_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lvfg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lvfg_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [lvfg_pkg::VOLT_W-1:0]       i_voltage_mv,
    input  logic [lvfg_pkg::TIME_W-1:0]       i_timestamp_s,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lvfg_pkg::PCT_W-1:0]        o_percent_hundredths,
    output logic [lvfg_pkg::MAH_W-1:0]        o_remaining_mah,
    output logic signed [lvfg_pkg::TL_W-1:0]  o_time_left_s,
    output logic                              o_estimate_valid
);
    import lvfg_pkg::*;

    localparam int WIN    = HISTORY_DEPTH + 1;
    localparam int IDX_W  = $clog2(WIN);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int NUM_W  = TERM_W + $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + DEN_W;
    localparam int RES_W  = PROD_W - FRAC_BITS;
    localparam int MB_W   = $clog2(DEN_W);
    localparam int ENT_W  = VOLT_W + TIME_W;

    t_state r_state, n_state;

    // Configuration
    logic [CELL_W-1:0] r_cells;
    logic [MAH_W-1:0]  r_cap;

    // Window bookkeeping
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_oldest;
    logic [IDX_W-1:0] r_rd_addr;
    logic [CNT_W-1:0] r_k;

    // Working registers
    logic [VOLT_W-1:0]       r_v;
    logic [VOLT_W-1:0]       r_prev_v, r_cur_v;
    logic [TIME_W-1:0]       r_prev_t, r_cur_t;
    logic                    r_term_neg;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_mcand;
    logic [DEN_W-1:0]        r_mplier;
    logic [MB_W-1:0]         r_mbit;
    logic [PROD_W-1:0]       r_acc;
    logic [PCT_W-1:0]        r_pct;
    logic [CAPX_W-1:0]       r_cap_prod;
    logic [MAH_W-1:0]        r_mah;
    logic [TL_W-1:0]         r_tl;
    logic                    r_est;

    // Output register
    logic              r_out_valid;
    logic [PCT_W-1:0]  r_out_pct;
    logic [MAH_W-1:0]  r_out_mah;
    logic [TL_W-1:0]   r_out_tl;
    logic              r_out_est;

    logic w_accept, w_out_xfer, w_out_free;
    logic w_div_start, w_div_done, w_ram_re;
    logic [NUM_W-1:0] w_div_num, w_div_quo;
    logic [DEN_W-1:0] w_div_den;
    logic [ENT_W-1:0] w_rdata;

    logic [CELL_W-1:0]     w_cells;
    logic [VOLT_W-1:0]     w_lo;
    logic [VOLT_W:0]       w_rem;
    logic [VOLT_W-1:0]     w_mr;
    logic [20:0]           w_pct_num;
    logic [CAP_PROD_W-1:0] w_cap_full;
    logic [VOLT_W:0]       w_dv;
    logic [TIME_W:0]       w_dt;
    logic [VOLT_W-1:0]     w_dv_mag;
    logic [TIME_W-1:0]     w_dt_mag;
    logic                  w_pair_go;
    logic [SUM_W-1:0]      w_sum_mag;
    logic [IDX_W:0]        w_slot_sum;
    logic [IDX_W-1:0]      w_slot;
    logic [IDX_W-1:0]      w_oldest_inc;
    logic [IDX_W-1:0]      w_rd_inc;
    logic [RES_W-1:0]      w_res;
    logic [TL_W-1:0]       w_tl;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_xfer = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Datapath arithmetic
    always_comb begin
        w_cells   = (r_cells == '0) ? CELL_W'(1) : r_cells;
        w_lo      = VOLT_W'(32'(w_cells) * 32'(MV_EMPTY_PER_CELL));
        w_rem     = {1'b0, r_v} - {1'b0, w_lo};
        w_mr      = w_rem[VOLT_W] ? VOLT_W'(-w_rem) : w_rem[VOLT_W-1:0];
        w_pct_num = (r_v > w_lo) ? 21'(32'(r_v - w_lo) * 32'(PCT_SCALE)) : '0;
        w_cap_full = CAP_PROD_W'(r_cap_prod) * CAP_PROD_W'(CAP_RECIP);
        w_dv      = {1'b0, r_prev_v} - {1'b0, r_cur_v};
        w_dt      = {1'b0, r_cur_t} - {1'b0, r_prev_t};
        w_dv_mag  = w_dv[VOLT_W] ? VOLT_W'(-w_dv) : w_dv[VOLT_W-1:0];
        w_dt_mag  = w_dt[TIME_W] ? TIME_W'(-w_dt) : w_dt[TIME_W-1:0];
        w_pair_go = (r_k != '0) && (w_dv != '0);
        w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

        w_slot_sum   = {1'b0, r_oldest} + (IDX_W+1)'(r_count);
        w_slot       = (w_slot_sum >= (IDX_W+1)'(WIN)) ?
                       IDX_W'(w_slot_sum - (IDX_W+1)'(WIN)) : w_slot_sum[IDX_W-1:0];
        w_oldest_inc = (r_oldest == IDX_W'(WIN - 1)) ? '0 : r_oldest + 1'b1;
        w_rd_inc     = (r_rd_addr == IDX_W'(WIN - 1)) ? '0 : r_rd_addr + 1'b1;

        w_res = r_acc[PROD_W-1:FRAC_BITS];
        if (r_neg) begin
            if (w_res > RES_W'(33'h1_0000_0000 >> 1)) begin
                w_tl = TL_W'(33'h1_0000_0000 >> 1);
            end else begin
                w_tl = TL_W'(-w_res);
            end
        end else begin
            if (w_res > RES_W'(32'h7FFF_FFFF)) begin
                w_tl = 32'h7FFF_FFFF;
            end else begin
                w_tl = w_res[TL_W-1:0];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_valid) n_state = ST_PCT;
            ST_PCT:       n_state = ST_PCT_WAIT;
            ST_PCT_WAIT:  if (w_div_done) n_state = ST_CAP;
            ST_CAP:       n_state = ST_CAP_WAIT;
            ST_CAP_WAIT:  n_state = (r_count < CNT_W'(2)) ? ST_DONE : ST_RD;
            ST_RD:        n_state = ST_LAT;
            ST_LAT:       n_state = ST_PAIR;
            ST_PAIR:      n_state = w_pair_go ? ST_PAIR_WAIT : ST_NEXT;
            ST_PAIR_WAIT: if (w_div_done) n_state = ST_NEXT;
            ST_NEXT:      n_state = (r_k + 1'b1 == r_count) ? ST_MEAN : ST_RD;
            ST_MEAN:      n_state = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (w_div_done) n_state = ST_MUL;
            ST_MUL:       if (r_mbit == MB_W'(DEN_W - 1)) n_state = ST_SAT;
            ST_SAT:       n_state = ST_DONE;
            ST_DONE:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control outputs and divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_ram_re    = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            ST_PCT: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(w_pct_num);
                w_div_den   = DEN_W'(w_cells);
            end
            ST_RD: begin
                w_ram_re = 1'b1;
            end
            ST_PAIR: begin
                w_div_start = w_pair_go;
                w_div_num   = NUM_W'({w_dt_mag, {FRAC_BITS{1'b0}}});
                w_div_den   = w_dv_mag;
            end
            ST_MEAN: begin
                w_div_start = 1'b1;
                w_div_num   = w_sum_mag[NUM_W-1:0];
                w_div_den   = DEN_W'(r_count - 1'b1);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cells     <= CELLS_RST;
            r_cap       <= CAP_RST;
            r_count     <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CELL_COUNT: r_cells <= i_cfg_data[CELL_W-1:0];
                    CFG_TOTAL_CAP:  r_cap   <= i_cfg_data[MAH_W-1:0];
                    default:        r_cap   <= r_cap;
                endcase
            end

            if (w_accept) begin
                r_v <= i_voltage_mv;
                if (r_count < CNT_W'(WIN)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_oldest <= w_oldest_inc;
                end
            end

            if (r_state == ST_PCT_WAIT && w_div_done) begin
                r_pct <= (w_div_quo > NUM_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                       : w_div_quo[PCT_W-1:0];
            end

            if (r_state == ST_CAP) begin
                r_cap_prod <= CAPX_W'((32'(r_cap) * 32'(r_pct)) >> CAP_PRE_SHIFT);
            end

            if (r_state == ST_CAP_WAIT) begin
                r_mah     <= MAH_W'(w_cap_full >> CAP_SHIFT);
                r_tl      <= '1;
                r_est     <= 1'b0;
                r_rd_addr <= r_oldest;
                r_k       <= '0;
                r_sum     <= '0;
            end

            if (r_state == ST_LAT) begin
                r_cur_v <= w_rdata[ENT_W-1:TIME_W];
                r_cur_t <= w_rdata[TIME_W-1:0];
            end

            if (r_state == ST_PAIR) begin
                r_term_neg <= w_dv[VOLT_W] ^ w_dt[TIME_W];
            end

            if (r_state == ST_PAIR_WAIT && w_div_done) begin
                r_sum <= r_term_neg ? r_sum - SUM_W'(w_div_quo)
                                    : r_sum + SUM_W'(w_div_quo);
            end

            // Advance to the next window entry
            if (r_state == ST_NEXT) begin
                r_prev_v  <= r_cur_v;
                r_prev_t  <= r_cur_t;
                r_k       <= r_k + 1'b1;
                r_rd_addr <= w_rd_inc;
            end

            if (r_state == ST_MEAN_WAIT && w_div_done) begin
                r_neg    <= r_sum[SUM_W-1] ^ w_rem[VOLT_W];
                r_mcand  <= PROD_W'(w_div_quo);
                r_mplier <= w_mr;
                r_mbit   <= '0;
                r_acc    <= '0;
            end

            // Shift-add multiply of mean magnitude by voltage headroom
            if (r_state == ST_MUL) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_mbit   <= r_mbit + 1'b1;
            end

            if (r_state == ST_SAT) begin
                r_tl  <= w_tl;
                r_est <= 1'b1;
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_pct   <= r_pct;
                r_out_mah   <= r_mah;
                r_out_tl    <= r_tl;
                r_out_est   <= r_est;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    lvfg_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WIN)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr ((r_count < CNT_W'(WIN)) ? w_slot : r_oldest),
        .i_wdata ({i_voltage_mv, i_timestamp_s}),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    lvfg_divu #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_percent_hundredths = r_out_pct;
    assign o_remaining_mah      = r_out_mah;
    assign o_time_left_s        = r_out_tl;
    assign o_estimate_valid     = r_out_est;

endmodule

// ----- design/lvfg_checker.sv -----
// Port-level checks of the fuel gauge and their binding to the top level.
module lvfg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [lvfg_pkg::PCT_W-1:0]        o_percent_hundredths,
    input logic signed [lvfg_pkg::TL_W-1:0]  o_time_left_s,
    input logic                              o_estimate_valid
);
    import lvfg_pkg::*;

    // A transfer in starts the sequencer, so the input side blocks next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not blocked after transfer");

    a_short_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_estimate_valid |-> o_time_left_s == -32'sd1)
        else $error("time left not -1 without estimate");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_percent_hundredths <= PCT_W'(PCT_MAX))
        else $error("percent above full scale");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_time_left_s)
                                       && $stable(o_percent_hundredths))
        else $error("stalled result changed");

endmodule

bind lipo_voltage_fuel_gauge lvfg_checker u_lvfg_checker (.*);

// ----- tb/tb_lipo_voltage_fuel_gauge.sv -----
// Testbench for the LiPo voltage fuel gauge: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module tb_lipo_voltage_fuel_gauge;
    import lvfg_pkg::*;

    localparam int WINDOW_LEN = HISTORY_DEPTH_DEF + 1;

    typedef struct {
        logic [PCT_W-1:0]         pct;
        logic [MAH_W-1:0]         mah;
        logic signed [TL_W-1:0]   tleft;
        logic                     est_ok;
    } t_gauge_reading;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [VOLT_W-1:0]       i_voltage_mv;
    logic [TIME_W-1:0]       i_timestamp_s;
    logic                    o_valid;
    logic                    i_stall;
    logic [PCT_W-1:0]        o_percent_hundredths;
    logic [MAH_W-1:0]        o_remaining_mah;
    logic signed [TL_W-1:0]  o_time_left_s;
    logic                    o_estimate_valid;

    lipo_voltage_fuel_gauge dut (.*);

    // predictor state
    logic [CELL_W-1:0]  pack_cells;
    logic [MAH_W-1:0]   pack_capacity;
    logic [VOLT_W-1:0]  hist_volt[$];
    logic [TIME_W-1:0]  hist_time[$];

    t_gauge_reading     pending_readings[$];
    int                 mismatch_count;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    logic [VOLT_W-1:0]  cur_volt;
    logic [TIME_W-1:0]  cur_time;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_gauge_reading predict_reading(input logic [VOLT_W-1:0] v,
                                                       input logic [TIME_W-1:0] t);
        t_gauge_reading r;
        longint cells, floor_mv, pct, sum, avg, rem, dv, dt, tl;
        longint unsigned ma, mr, res;
        bit neg;
        hist_volt.insert(hist_volt.size(), v);
        hist_time.insert(hist_time.size(), t);
        if (hist_volt.size() > WINDOW_LEN) begin
            hist_volt.delete(0);
            hist_time.delete(0);
        end
        cells = (pack_cells == 0) ? 1 : pack_cells;
        floor_mv = cells * MV_EMPTY_PER_CELL;
        if (v <= floor_mv) pct = 0;
        else pct = (longint'(v) - floor_mv) * PCT_SCALE / cells;
        if (pct > PCT_MAX) pct = PCT_MAX;
        r.pct = pct[PCT_W-1:0];
        r.mah = MAH_W'(longint'(pack_capacity) * pct / CAP_DIV);
        if (hist_volt.size() < 2) begin
            r.tleft = -1;
            r.est_ok = 1'b0;
            return r;
        end
        sum = 0;
        for (int k = 1; k < hist_volt.size(); k++) begin
            dv = longint'(hist_volt[k-1]) - longint'(hist_volt[k]);
            dt = longint'(hist_time[k]) - longint'(hist_time[k-1]);
            if (dv != 0) sum += (dt * (longint'(1) << FRAC_BITS)) / dv;
        end
        avg = sum / longint'(hist_volt.size() - 1);
        rem = longint'(v) - floor_mv;
        neg = (avg < 0) != (rem < 0);
        ma = (avg < 0) ? -avg : avg;
        mr = (rem < 0) ? -rem : rem;
        if (ma == 0 || mr == 0) begin
            tl = 0;
        end else begin
            if (ma > (64'd1 << 62) / mr) res = 64'd1 << 40;
            else res = (ma * mr) >> FRAC_BITS;
            if (neg) begin
                if (res > 64'd2147483648) res = 64'd2147483648;
                tl = -longint'(res);
            end else begin
                if (res > 64'd2147483647) res = 64'd2147483647;
                tl = longint'(res);
            end
        end
        r.tleft = tl[TL_W-1:0];
        r.est_ok = 1'b1;
        return r;
    endfunction

    // Receiver side: drive stall at the falling edge, check each result transfer at the rising edge.
    initial begin
        t_gauge_reading want;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < rx_idle_pct);
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: pct %0d mah %0d tl %0d ok %0b",
                                 o_percent_hundredths, o_remaining_mah, o_time_left_s,
                                 o_estimate_valid);
                end else begin
                    want = pending_readings[0];
                    pending_readings.delete(0);
                    if (o_percent_hundredths !== want.pct || o_remaining_mah !== want.mah ||
                        o_time_left_s !== want.tleft || o_estimate_valid !== want.est_ok) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp pct %0d mah %0d tl %0d ok %0b, got pct %0d mah %0d tl %0d ok %0b",
                                     want.pct, want.mah, want.tleft, want.est_ok,
                                     o_percent_hundredths, o_remaining_mah, o_time_left_s,
                                     o_estimate_valid);
                    end
                end
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for back-to-back transfers.
    task automatic send_sample(input logic [VOLT_W-1:0] v, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_voltage_mv <= v;
        i_timestamp_s <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_readings.insert(pending_readings.size(), predict_reading(v, t));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CELL_COUNT) pack_cells = data[CELL_W-1:0];
        else pack_capacity = data[MAH_W-1:0];
    endtask

    task automatic test_defaults_and_short_history();
        send_sample(16'd11000, 32'd0);
        send_sample(16'd11000, 32'd10);          // zero drop pair
        send_sample(16'd12600, 32'd20);          // voltage rise
        send_sample(16'd11500, 32'd15);          // timestamp goes backward
        send_sample(16'd0, 32'hFFFF_FFFF);
        send_sample(16'hFFFF, 32'd0);
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_CELL_COUNT, 16'd0);        // zero cells acts as one
        write_reg(CFG_TOTAL_CAP, 16'hFFFF);
        send_sample(16'd4200, 32'd100);
        send_sample(16'd3700, 32'd200);
        send_sample(16'd3950, 32'd300);
        send_sample(16'd3949, 32'hFFFF_FFFF);    // huge term, saturate high
        send_sample(16'hFFFF, 32'hFFFF_FFFF);
        drain_results();
        write_reg(CFG_CELL_COUNT, 16'hFFFF);     // upper bits dropped, 15 cells
        write_reg(CFG_TOTAL_CAP, 16'd0);
        send_sample(16'd58000, 32'd10);
        send_sample(16'd55500, 32'd20);
        send_sample(16'd63000, 32'd30);
        drain_results();
        write_reg(CFG_CELL_COUNT, 16'd14);
        write_reg(CFG_TOTAL_CAP, 16'd1);
        send_sample(16'd58800, 32'd40);
        send_sample(16'd51800, 32'd50);
        send_sample(16'd51799, 32'd0);
        send_sample(16'd51801, 32'hFFFF_FFFF);   // rise with huge dt
        drain_results();
        write_reg(CFG_CELL_COUNT, 16'd1);
        write_reg(CFG_TOTAL_CAP, 16'd5000);
        send_sample(16'd4100, 32'd0);
        send_sample(16'd4100, 32'd0);
        drain_results();
    endtask

    task automatic test_random_discharge(input int items, input int tx_pct, input int rx_pct);
        int cells;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < items; n++) begin
            if (n % 100 == 0) begin
                drain_results();
                cells = $urandom_range(15);
                write_reg(CFG_CELL_COUNT, CFG_W'(cells));
                write_reg(CFG_TOTAL_CAP, CFG_W'($urandom_range(65535)));
                if (cells == 0) cells = 1;
                cur_volt = VOLT_W'(cells * 3650 + $urandom_range(cells * 650));
                cur_time = $urandom;
            end
            case ($urandom_range(19))
                0: begin
                    cur_volt = VOLT_W'($urandom);
                    cur_time = $urandom;
                end
                1: cur_time = cur_time - $urandom_range(50);
                2: cur_volt = cur_volt + VOLT_W'($urandom_range(200));
                default: begin
                    cur_volt = cur_volt - VOLT_W'($urandom_range(25));
                    cur_time = cur_time + $urandom_range(900);
                end
            endcase
            send_sample(cur_volt, cur_time);
        end
        drain_results();
    endtask

    initial begin
        i_clk = 1'b0;
        mismatch_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pack_cells = CELLS_RST;
        pack_capacity = CAP_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CELL_COUNT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_voltage_mv = '0;
        i_timestamp_s = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_defaults_and_short_history();
        test_register_extremes();
        test_random_discharge(530, 38, 76);
        test_random_discharge(530, 76, 38);
        test_random_discharge(540, 0, 0);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- lipo_voltage_fuel_gauge.f -----
design/lvfg_pkg.sv
design/lvfg_ram.sv
design/lvfg_divu.sv
design/lipo_voltage_fuel_gauge.sv
design/lvfg_checker.sv
tb/tb_lipo_voltage_fuel_gauge.sv
